>>> rtl/core/icdf_pkg.sv
// Shared types and constants for the inverse-CDF sampling histogram core.
`default_nettype none
package icdf_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int COUNT_BITS_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int CDF_W   = 33;
  localparam int ECNT_W  = 11;
  localparam int IDX_O_W = 10;
  localparam int TOTAL_W = 32;

  localparam logic [ECNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;
  localparam logic [CDF_W-1:0]  ONE_Q32         = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_HIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [VALUE_W-1:0]   value;
    logic [IDX_O_W-1:0]   entry_index;
  } in_word_t;

  typedef struct packed {
    logic [IDX_O_W-1:0]   chosen_index;
    logic [TOTAL_W-1:0]   entry_total;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/core/inverse_cdf_sampling_histogram_core.sv
// Draw: k <= ceil(log2(entries+1)) search steps, each a table RAM read and then a
// compare, before the result strobe. A load returns nothing; busy stays low. One word
// is in flight at a time; busy drops in the cycle the result strobe shows. After reset
// and after a clear word, busy stays high while the counter RAM is swept to zero.
// The result strobe cannot be stalled.
`default_nettype none
module inverse_cdf_sampling_histogram_core
  import icdf_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire in_word_t          in_word,
  output      logic              out_valid,
  output      out_word_t         out_word,
  input  wire logic              cfg_we,
  input  wire logic [ECNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int N_W   = IDX_W + 1;

  logic [ECNT_W-1:0]     entry_count_r, entry_count_nxt;
  logic [N_W-1:0]        n_used;

  logic                  cdf_we;
  logic [IDX_W-1:0]      cdf_waddr, cdf_raddr;
  logic [CDF_W-1:0]      cdf_wdata, cdf_rdata;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

  assign entry_count_nxt = cfg_we ? cfg_wdata : entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RST;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // A count of zero acts as one; counts above the table depth act as the depth.
  always_comb begin
    if (entry_count_r == '0) begin
      n_used = N_W'(1);
    end else if (32'(entry_count_r) > DEPTH) begin
      n_used = N_W'(DEPTH);
    end else begin
      n_used = N_W'(entry_count_r);
    end
  end

  icdf_ctrl #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .n_used    (n_used),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cdf_we    (cdf_we),
    .cdf_waddr (cdf_waddr),
    .cdf_wdata (cdf_wdata),
    .cdf_raddr (cdf_raddr),
    .cdf_rdata (cdf_rdata),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata)
  );

  icdf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (CDF_W)
  ) u_cdf_ram (
    .clk     (clk),
    .we      (cdf_we),
    .waddr   (cdf_waddr),
    .wdata   (cdf_wdata),
    .raddr   (cdf_raddr),
    .rdata_r (cdf_rdata)
  );

  icdf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (COUNT_BITS)
  ) u_cnt_ram (
    .clk     (clk),
    .we      (cnt_we),
    .waddr   (cnt_waddr),
    .wdata   (cnt_wdata),
    .raddr   (cnt_raddr),
    .rdata_r (cnt_rdata)
  );

endmodule
`default_nettype wire

>>> rtl/core/icdf_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read output.
`default_nettype none
module icdf_ram
  import icdf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = CDF_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/icdf_ctrl.sv
// Sequencer: table loading, binary search, counter update, readout and clear sweep.
`default_nettype none
module icdf_ctrl
  import icdf_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int N_W       = IDX_W + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire in_word_t              in_word,
  input  wire logic [N_W-1:0]        n_used,
  output      logic                  busy,
  output      logic                  out_valid,
  output      out_word_t             out_word,
  output      logic                  cdf_we,
  output      logic [IDX_W-1:0]      cdf_waddr,
  output      logic [CDF_W-1:0]      cdf_wdata,
  output      logic [IDX_W-1:0]      cdf_raddr,
  input  wire logic [CDF_W-1:0]      cdf_rdata,
  output      logic                  cnt_we,
  output      logic [IDX_W-1:0]      cnt_waddr,
  output      logic [COUNT_BITS-1:0] cnt_wdata,
  output      logic [IDX_W-1:0]      cnt_raddr,
  input  wire logic [COUNT_BITS-1:0] cnt_rdata
);

  state_t               state_r, state_nxt;
  logic [N_W-1:0]       lo_r, lo_nxt;
  logic [N_W-1:0]       hi_r, hi_nxt;
  logic [N_W-1:0]       mid_r, mid_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [IDX_W-1:0]     sweep_r, sweep_nxt;
  logic [IDX_W-1:0]     sel_r, sel_nxt;
  logic [IDX_O_W-1:0]   rep_idx_r, rep_idx_nxt;
  logic                 in_range_r, in_range_nxt;
  logic [CDF_W-1:0]     sum_r, sum_nxt;
  logic [N_W-1:0]       load_pos_r, load_pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic                 accept;
  logic [N_W-1:0]       n_m1;
  logic [N_W-1:0]       mid_calc;
  logic [N_W-1:0]       sel_calc;
  logic [CDF_W:0]       sum_wide;
  logic [CDF_W-1:0]     sum_sat;
  logic [CDF_W-1:0]     eff_cdf;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [63:0]          inc_wide;
  logic [63:0]          rd_wide;
  logic [31:0]          sel_wide;
  logic                 sweep_last;

  assign accept     = start && (state_r == ST_IDLE);
  assign n_m1       = n_used - 1'b1;
  assign mid_calc   = lo_r + ((hi_r - lo_r) >> 1);
  assign sel_calc   = (lo_r >= n_used) ? n_m1 : lo_r;
  assign sum_wide   = {1'b0, sum_r} + (CDF_W+1)'(in_word.value);
  assign sum_sat    = (sum_wide > (CDF_W+1)'(ONE_Q32)) ? ONE_Q32 : sum_wide[CDF_W-1:0];
  // The last entry in use always reads as exactly 1.0.
  assign eff_cdf    = (mid_r == n_m1) ? ONE_Q32 : cdf_rdata;
  assign cnt_inc    = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1;
  assign inc_wide   = 64'(cnt_inc);
  assign rd_wide    = 64'(cnt_rdata);
  assign sel_wide   = 32'(sel_r);
  assign sweep_last = (sweep_r == IDX_W'(DEPTH - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_word.mode)
            MODE_DRAW:  state_nxt = ST_SRCH_ADDR;
            MODE_READ:  state_nxt = ST_REPORT;
            MODE_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRCH_ADDR: begin
        state_nxt = (lo_r < hi_r) ? ST_SRCH_CMP : ST_HIT;
      end
      ST_SRCH_CMP: state_nxt = ST_SRCH_ADDR;
      ST_HIT:      state_nxt = ST_IDLE;
      ST_REPORT:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory ports and datapath registers.
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    value_nxt     = value_r;
    sweep_nxt     = sweep_r;
    sel_nxt       = sel_r;
    rep_idx_nxt   = rep_idx_r;
    in_range_nxt  = in_range_r;
    sum_nxt       = sum_r;
    load_pos_nxt  = load_pos_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    cdf_we        = 1'b0;
    cdf_waddr     = load_pos_r[IDX_W-1:0];
    cdf_wdata     = sum_sat;
    cdf_raddr     = mid_calc[IDX_W-1:0];
    cnt_we        = 1'b0;
    cnt_waddr     = sel_r;
    cnt_wdata     = cnt_inc;
    cnt_raddr     = IDX_W'(in_word.entry_index);
    case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_r;
        cnt_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_word.mode)
            MODE_LOAD: begin
              // Loads past the entries in use are dropped.
              if (load_pos_r < n_used) begin
                cdf_we       = 1'b1;
                sum_nxt      = sum_sat;
                load_pos_nxt = load_pos_r + 1'b1;
              end
            end
            MODE_DRAW: begin
              lo_nxt    = '0;
              hi_nxt    = n_used;
              value_nxt = in_word.value;
            end
            MODE_READ: begin
              rep_idx_nxt  = in_word.entry_index;
              in_range_nxt = (32'(in_word.entry_index) < DEPTH);
            end
            MODE_CLEAR: begin
              sum_nxt      = '0;
              load_pos_nxt = '0;
              sweep_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH_ADDR: begin
        mid_nxt   = mid_calc;
        cnt_raddr = sel_calc[IDX_W-1:0];
        sel_nxt   = sel_calc[IDX_W-1:0];
      end
      ST_SRCH_CMP: begin
        if (eff_cdf < {1'b0, value_r}) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
      end
      ST_HIT: begin
        cnt_we                    = 1'b1;
        out_valid_nxt             = 1'b1;
        out_word_nxt.chosen_index = sel_wide[IDX_O_W-1:0];
        out_word_nxt.entry_total  = (inc_wide > 64'hFFFF_FFFF) ? '1 : inc_wide[TOTAL_W-1:0];
      end
      ST_REPORT: begin
        out_valid_nxt             = 1'b1;
        out_word_nxt.chosen_index = rep_idx_r;
        if (!in_range_r) begin
          out_word_nxt.entry_total = '0;
        end else if (rd_wide > 64'hFFFF_FFFF) begin
          out_word_nxt.entry_total = '1;
        end else begin
          out_word_nxt.entry_total = rd_wide[TOTAL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      sum_r       <= '0;
      load_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      sum_r       <= sum_nxt;
      load_pos_r  <= load_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    value_r    <= value_nxt;
    sel_r      <= sel_nxt;
    rep_idx_r  <= rep_idx_nxt;
    in_range_r <= in_range_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
